### rtl/msp_pkg.sv
// msp_pkg: shared types and constants for the multiplexed servo pulse generator.
// Used by msp_core, msp_rsp_buf and multiplexed_servo_pulse_generator.
package msp_pkg;

   localparam int SLOTS_DEFAULT      = 12;
   localparam int COUNT_BITS_DEFAULT = 20;

   localparam int PIN_BITS    = 12;
   localparam int SLOT_BITS   = 5;
   localparam int IDX_IN_BITS = 4;
   localparam int PULSE_BITS  = 16;
   localparam int SCOUNT_BITS = 4;
   localparam int CFG_BITS    = 20;
   localparam int GUARD_BITS  = 8;
   localparam int CSR_IDX_BITS = 2;
   // wide enough for any saturating sum of a counter and a width or guard
   localparam int SUM_BITS    = 33;

   localparam logic [CFG_BITS-1:0]    REFRESH_RESET = CFG_BITS'(52500);
   localparam logic [GUARD_BITS-1:0]  GUARD_RESET   = GUARD_BITS'(4);
   localparam logic [CFG_BITS-1:0]    START_RESET   = CFG_BITS'(2625);

   typedef enum logic [1:0] {
      CMD_TICK     = 2'd0,
      CMD_SET_SLOT = 2'd1,
      CMD_ENABLE   = 2'd2,
      CMD_DISABLE  = 2'd3
   } cmd_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_SERVO_COUNT = 2'd0,
      CSR_REFRESH     = 2'd1,
      CSR_GUARD       = 2'd2,
      CSR_START_DELAY = 2'd3
   } csr_type;

   typedef struct packed {
      cmd_type                 command;
      logic [IDX_IN_BITS-1:0]  slot_index;
      logic [PULSE_BITS-1:0]   pulse_ticks;
      logic                    slot_active;
   } req_type;

   typedef struct packed {
      logic [PIN_BITS-1:0]         pin_levels;
      logic                        group_running;
      logic signed [SLOT_BITS-1:0] current_slot;
      logic                        event_fired;
   } rsp_type;

   typedef struct packed {
      logic                    valid;
      logic [CSR_IDX_BITS-1:0] index;
      logic [CFG_BITS-1:0]     data;
   } csr_wr_type;

endpackage

### rtl/msp_core.sv
// msp_core: configuration registers, timer group state and the per-item step logic.
// Depends on msp_pkg. Produces one result per processed item.
module msp_core #(
   parameter int SLOTS      = msp_pkg::SLOTS_DEFAULT,
   parameter int COUNT_BITS = msp_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  msp_pkg::csr_wr_type  csr_wr,
   input  logic                 go,
   input  msp_pkg::req_type     item,
   output msp_pkg::rsp_type     result
);

   localparam int IDX_BITS = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int SB = msp_pkg::SLOT_BITS;
   localparam int SW = msp_pkg::SUM_BITS;
   localparam logic [SW-1:0] CNT_MAX_W = (SW'(1) << COUNT_BITS) - SW'(1);

   function automatic logic [COUNT_BITS-1:0] sat_cnt(input logic [SW-1:0] v);
      return (v > CNT_MAX_W) ? CNT_MAX_W[COUNT_BITS-1:0] : v[COUNT_BITS-1:0];
   endfunction

   // configuration
   logic [msp_pkg::SCOUNT_BITS-1:0] servo_count_ff;
   logic [msp_pkg::CFG_BITS-1:0]    refresh_ff;
   logic [msp_pkg::GUARD_BITS-1:0]  guard_ff;
   logic [msp_pkg::CFG_BITS-1:0]    start_ff;

   // group state
   logic [COUNT_BITS-1:0] cnt_ff, cnt_in;
   logic [COUNT_BITS-1:0] cmp_ff, cmp_in;
   logic signed [SB-1:0]  slot_ff, slot_in;
   logic                  run_ff, run_in;
   logic                  stop_ff, stop_in;
   logic [msp_pkg::PULSE_BITS-1:0] width_ff [SLOTS];
   logic [SLOTS-1:0]      active_ff;
   logic [SLOTS-1:0]      pin_ff, pin_in;

   logic [COUNT_BITS-1:0] cnt_inc;
   logic [COUNT_BITS-1:0] cnt_base;
   logic [SB-1:0]         served;
   logic [SB-1:0]         next_slot;
   logic [IDX_BITS-1:0]   cur_idx;
   logic [IDX_BITS-1:0]   next_idx;
   logic                  cur_served;
   logic                  next_served;
   logic [COUNT_BITS-1:0] cmp_pulse;
   logic [COUNT_BITS-1:0] cmp_guard;
   logic [COUNT_BITS-1:0] cmp_refresh;
   logic                  fired;
   logic                  set_ok;

   assign cnt_inc   = cnt_ff + COUNT_BITS'(1);
   // frame end restarts the counter before the next compare point is formed
   assign cnt_base  = slot_ff[SB-1] ? '0 : cnt_inc;
   assign served    = ({1'b0, servo_count_ff} > SB'(SLOTS)) ? SB'(SLOTS)
                                                            : {1'b0, servo_count_ff};
   assign next_slot = slot_ff + SB'(1);
   assign cur_idx   = slot_ff[IDX_BITS-1:0];
   assign next_idx  = next_slot[IDX_BITS-1:0];
   assign cur_served  = !slot_ff[SB-1] && (slot_ff < served);
   assign next_served = next_slot < served;
   assign cmp_pulse   = sat_cnt(SW'(cnt_base) + SW'(width_ff[next_idx]));
   assign cmp_guard   = sat_cnt(SW'(cnt_base) + SW'(guard_ff));
   assign cmp_refresh = sat_cnt(SW'(refresh_ff));
   assign set_ok      = {1'b0, item.slot_index} < SB'(SLOTS);

   always_comb begin
      cnt_in  = cnt_ff;
      cmp_in  = cmp_ff;
      slot_in = slot_ff;
      run_in  = run_ff;
      stop_in = stop_ff;
      pin_in  = pin_ff;
      fired   = 1'b0;
      if (go) begin
         case (item.command)
            msp_pkg::CMD_TICK: begin
               if (run_ff) begin
                  cnt_in = cnt_inc;
                  if (cnt_inc == cmp_ff) begin
                     fired = 1'b1;
                     if (slot_ff[SB-1]) begin
                        cnt_in = '0;
                     end
                     if (cur_served) begin
                        pin_in[cur_idx] = 1'b0;
                     end
                     if (slot_ff[SB-1] && stop_ff) begin
                        stop_in = 1'b0;
                        run_in  = 1'b0;
                     end else if (next_served) begin
                        slot_in = next_slot;
                        cmp_in  = cmp_pulse;
                        if (active_ff[next_idx]) begin
                           pin_in[next_idx] = 1'b1;
                        end
                     end else begin
                        slot_in = '1;
                        cmp_in  = (cmp_guard > cmp_refresh) ? cmp_guard : cmp_refresh;
                     end
                  end
               end
            end
            msp_pkg::CMD_ENABLE: begin
               if (stop_ff) begin
                  stop_in = 1'b0;
               end else begin
                  cmp_in = sat_cnt(SW'(start_ff));
                  cnt_in = '0;
                  run_in = 1'b1;
               end
            end
            msp_pkg::CMD_DISABLE: begin
               stop_in = 1'b1;
            end
            default: begin
               // slot table write happens in the clocked block
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         servo_count_ff <= '0;
         refresh_ff     <= msp_pkg::REFRESH_RESET;
         guard_ff       <= msp_pkg::GUARD_RESET;
         start_ff       <= msp_pkg::START_RESET;
         cnt_ff         <= '0;
         cmp_ff         <= '0;
         slot_ff        <= '0;
         run_ff         <= 1'b0;
         stop_ff        <= 1'b0;
         active_ff      <= '0;
         pin_ff         <= '0;
         for (int i = 0; i < SLOTS; i++) begin
            width_ff[i] <= '0;
         end
      end else begin
         if (csr_wr.valid) begin
            case (msp_pkg::csr_type'(csr_wr.index))
               msp_pkg::CSR_SERVO_COUNT: servo_count_ff <= csr_wr.data[msp_pkg::SCOUNT_BITS-1:0];
               msp_pkg::CSR_REFRESH:     refresh_ff     <= csr_wr.data;
               msp_pkg::CSR_GUARD:       guard_ff       <= csr_wr.data[msp_pkg::GUARD_BITS-1:0];
               msp_pkg::CSR_START_DELAY: start_ff       <= csr_wr.data;
               default: begin
               end
            endcase
         end
         cnt_ff  <= cnt_in;
         cmp_ff  <= cmp_in;
         slot_ff <= slot_in;
         run_ff  <= run_in;
         stop_ff <= stop_in;
         pin_ff  <= pin_in;
         if (go && item.command == msp_pkg::CMD_SET_SLOT && set_ok) begin
            width_ff[item.slot_index[IDX_BITS-1:0]]  <= item.pulse_ticks;
            active_ff[item.slot_index[IDX_BITS-1:0]] <= item.slot_active;
         end
      end
   end

   // only the first twelve slots are visible on the result
   for (genvar g = 0; g < msp_pkg::PIN_BITS; g++) begin : g_pins
      if (g < SLOTS) begin : g_on
         assign result.pin_levels[g] = pin_in[g];
      end else begin : g_off
         assign result.pin_levels[g] = 1'b0;
      end
   end

   assign result.group_running = run_in;
   assign result.current_slot  = slot_in;
   assign result.event_fired   = fired;

endmodule

### rtl/msp_rsp_buf.sv
// msp_rsp_buf: two-entry result buffer between the step logic and the rsp channel.
// Depends on msp_pkg for the result item type.
module msp_rsp_buf (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  msp_pkg::rsp_type  push_data,
   output logic              ready,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output msp_pkg::rsp_type  rsp_data
);

   msp_pkg::rsp_type ent_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             pop;

   assign ready     = (count_ff != 2'd2);
   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_data  = ent_ff[rd_ptr_ff];
   assign pop       = rsp_valid && !rsp_stall;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         ent_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### rtl/multiplexed_servo_pulse_generator.sv
// Channel  Direction  Handshake          Payload
// req      in         req_valid/stall    command, slot_index, pulse_ticks, slot_active
// rsp      out        rsp_valid/stall    pin_levels, group_running, current_slot, event_fired
// csr      in         csr_valid/ready    csr_index, csr_data
//
// One item per cycle sustained while the rsp side does not stall. An item is registered on accept,
// stepped through the group state and lands in a two-entry result buffer, from which its
// result is presented on the rsp channel. Reset is synchronous and needs no clearing pass.
// A stalled rsp side fills the buffer, then the input register, then raises req_stall.
// Depends on msp_pkg, msp_core and msp_rsp_buf.
module multiplexed_servo_pulse_generator #(
   parameter int SLOTS      = msp_pkg::SLOTS_DEFAULT,
   parameter int COUNT_BITS = msp_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [1:0]                           req_command,
   input  logic [msp_pkg::IDX_IN_BITS-1:0]      req_slot_index,
   input  logic [msp_pkg::PULSE_BITS-1:0]       req_pulse_ticks,
   input  logic                                 req_slot_active,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [msp_pkg::PIN_BITS-1:0]         rsp_pin_levels,
   output logic                                 rsp_group_running,
   output logic signed [msp_pkg::SLOT_BITS-1:0] rsp_current_slot,
   output logic                                 rsp_event_fired,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [msp_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  logic [msp_pkg::CFG_BITS-1:0]         csr_data
);

   msp_pkg::req_type    in_item_ff;
   logic                in_v_ff, in_v_in;
   logic                req_take;
   logic                core_go;
   logic                buf_ready;
   msp_pkg::rsp_type    core_rsp;
   msp_pkg::rsp_type    out_rsp;
   msp_pkg::csr_wr_type csr_wr;

   assign csr_ready    = 1'b1;
   assign csr_wr.valid = csr_valid;
   assign csr_wr.index = csr_index;
   assign csr_wr.data  = csr_data;

   assign core_go   = in_v_ff && buf_ready;
   assign req_stall = in_v_ff && !core_go;
   assign req_take  = req_valid && !req_stall;
   assign in_v_in   = req_take || (in_v_ff && !core_go);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff <= 1'b0;
      end else begin
         in_v_ff <= in_v_in;
      end
      if (req_take) begin
         in_item_ff.command     <= msp_pkg::cmd_type'(req_command);
         in_item_ff.slot_index  <= req_slot_index;
         in_item_ff.pulse_ticks <= req_pulse_ticks;
         in_item_ff.slot_active <= req_slot_active;
      end
   end

   msp_core #(
      .SLOTS      (SLOTS),
      .COUNT_BITS (COUNT_BITS)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .csr_wr (csr_wr),
      .go     (core_go),
      .item   (in_item_ff),
      .result (core_rsp)
   );

   msp_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (core_go),
      .push_data (core_rsp),
      .ready     (buf_ready),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (out_rsp)
   );

   assign rsp_pin_levels    = out_rsp.pin_levels;
   assign rsp_group_running = out_rsp.group_running;
   assign rsp_current_slot  = out_rsp.current_slot;
   assign rsp_event_fired   = out_rsp.event_fired;

   // an item taken while one is held must mean the held one moves on
   a_take_drains: assert property (@(posedge clock) disable iff (reset)
      (req_take && in_v_ff) |-> core_go)
      else $error("input register overwritten");

   // only a tick can meet the compare point
   a_fire_on_tick: assert property (@(posedge clock) disable iff (reset)
      (core_go && in_item_ff.command != msp_pkg::CMD_TICK) |-> !core_rsp.event_fired)
      else $error("event on a non-tick item");

   // slot position is either the waiting mark or a real slot
   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      core_go |-> (core_rsp.current_slot == -5'sd1) ||
                  (core_rsp.current_slot >= 0 && 32'(core_rsp.current_slot) < SLOTS))
      else $error("slot position out of range");

   // a result only leaves the buffer when the rsp side takes it
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      ($past(rsp_valid) && $past(rsp_stall) && !$past(reset)) |-> rsp_valid)
      else $error("result dropped under stall");

endmodule
